FILE: rtl/gvf_pkg.sv
// shared types, constants and tables for the gated velocity fusion block
`default_nettype none
package gvf_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicW     = 43;
    localparam int DivW        = 33;
    localparam int LatCordic   = CordicSteps + 1;
    localparam int LatDiv      = 50;
    localparam int Latency     = LatCordic + 3 + LatDiv + 2;

    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_ZERO_COV = 2'd1;
    localparam logic [1:0] REG_MOTION   = 2'd2;
    localparam logic [1:0] REG_REVERT   = 2'd3;

    typedef enum logic [1:0] {
        POL_SKIP      = 2'd0,
        POL_OVERWRITE = 2'd1,
        POL_FUSION    = 2'd2,
        POL_UNKNOWN   = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_MISMATCH  = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_OVERWRITE = 3'd2,
        ST_FUSED     = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic [31:0]               z;
        logic                      zero;
    } cordic_t;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [63:0]     quo;
        logic [DivW-1:0] den;
    } div_t;

    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051D;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2E;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517C;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A2F;
            19: t = 32'h00000517;
            20: t = 32'h0000028B;
            21: t = 32'h00000145;
            22: t = 32'h000000A2;
            23: t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic [15:0] angle_dist(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        logic [15:0] r;
        d = a - b;
        r = d[15] ? (16'd0 - d) : d;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gated_velocity_fusion.sv
// top level of the gated velocity fusion block
//
// one track pair is taken per cycle when start is high and busy is low;
// busy is tied low since the datapath is fully pipelined and carries no
// state between pairs. each pair gives exactly one result word on out_vx,
// out_cov, status and sub_reverted, marked by done for one cycle, once the
// pair has passed the cordic chain, the gating stages, the divider chain
// and the rounding stages. the divider chain sets the latency; throughput is
// one pair per cycle. config writes use cfg_valid/cfg_ready/cfg_index/
// cfg_data and are always ready; they must happen while no pair is in
// flight. reset clears the config registers to their defaults and drops
// all pending done strobes. the receiver cannot stall: a result that is
// shown is taken at the end of that cycle.
`default_nettype none
module gated_velocity_fusion
    import gvf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] main_heading,
    input  wire logic signed [15:0] main_vx,
    input  wire logic signed [15:0] main_vy,
    input  wire logic [31:0]        main_cov,
    input  wire logic signed [15:0] sub_yaw,
    input  wire logic signed [15:0] sub_vx,
    input  wire logic signed [15:0] sub_vy,
    input  wire logic [31:0]        sub_cov,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    done,
    output logic signed [15:0]      out_vx,
    output logic [31:0]             out_cov,
    output logic [2:0]              status,
    output logic                    sub_reverted
);
    policy_t     policy_reg;
    logic [31:0] zcov_reg;
    logic [15:0] motion_reg;
    logic [15:0] revert_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_SKIP;
            zcov_reg   <= 32'd1;
            motion_reg <= 16'd8192;
            revert_reg <= 16'd16384;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POLICY:   policy_reg <= policy_t'(cfg_data[1:0]);
                REG_ZERO_COV: zcov_reg   <= cfg_data;
                REG_MOTION:   motion_reg <= cfg_data[15:0];
                REG_REVERT:   revert_reg <= cfg_data[15:0];
                default:      policy_reg <= policy_reg;
            endcase
        end
    end

    // valid shift line
    logic [Latency-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Latency-2:0], start};
    end
    assign done = vld_reg[Latency-1];

    // cordic
    logic [15:0] m_ang;
    logic [15:0] s_ang;
    gvf_cordic u_cm (.clk(clk), .x(main_vx), .y(main_vy), .angle(m_ang));
    gvf_cordic u_cs (.clk(clk), .x(sub_vx),  .y(sub_vy),  .angle(s_ang));

    // payload delay across the cordic
    logic [15:0] dmy_reg [LatCordic];
    logic [15:0] dsy_reg [LatCordic];
    logic [15:0] dmv_reg [LatCordic];
    logic [15:0] dsv_reg [LatCordic];
    logic [31:0] dmc_reg [LatCordic];
    logic [31:0] dsc_reg [LatCordic];
    always_ff @(posedge clk)
    begin
        dmy_reg[0] <= main_heading;
        dsy_reg[0] <= sub_yaw;
        dmv_reg[0] <= main_vx;
        dsv_reg[0] <= sub_vx;
        dmc_reg[0] <= main_cov;
        dsc_reg[0] <= sub_cov;
        for (int i = 1; i < LatCordic; i++)
        begin
            dmy_reg[i] <= dmy_reg[i-1];
            dsy_reg[i] <= dsy_reg[i-1];
            dmv_reg[i] <= dmv_reg[i-1];
            dsv_reg[i] <= dsv_reg[i-1];
            dmc_reg[i] <= dmc_reg[i-1];
            dsc_reg[i] <= dsc_reg[i-1];
        end
    end

    // gate stage 1: directions and decisions
    logic [15:0] m_dir;
    logic [15:0] s_dir;
    logic        mism_next;
    logic        rev_next;
    logic signed [15:0] sv_next;
    assign m_dir = dmy_reg[LatCordic-1] + m_ang;
    assign s_dir = dsy_reg[LatCordic-1] + s_ang;
    assign mism_next = {1'b0, angle_dist(m_dir, s_dir)} >= {1'b0, motion_reg};
    assign rev_next  = angle_dist(dmy_reg[LatCordic-1], dsy_reg[LatCordic-1]) >= revert_reg;
    always_comb
    begin
        sv_next = dsv_reg[LatCordic-1];
        if (rev_next)
            sv_next = (sv_next == -16'sd32768) ? 16'sd32767 : -sv_next;
    end

    logic               g_mism_reg;
    logic               g_rev_reg;
    logic signed [15:0] g_mv_reg;
    logic signed [15:0] g_sv_reg;
    logic [31:0]        g_mc_reg;
    logic [31:0]        g_cm_reg;
    logic [31:0]        g_cs_reg;
    logic [31:0]        zc;
    assign zc = (zcov_reg == 32'd0) ? 32'd1 : zcov_reg;
    always_ff @(posedge clk)
    begin
        g_mism_reg <= mism_next;
        g_rev_reg  <= rev_next & ~mism_next;
        g_mv_reg   <= dmv_reg[LatCordic-1];
        g_sv_reg   <= sv_next;
        g_mc_reg   <= dmc_reg[LatCordic-1];
        g_cm_reg   <= (dmc_reg[LatCordic-1] == 32'd0) ? zc : dmc_reg[LatCordic-1];
        g_cs_reg   <= (dsc_reg[LatCordic-1] == 32'd0) ? zc : dsc_reg[LatCordic-1];
    end

    // gate stage 2: products
    logic signed [48:0] p1_reg;
    logic signed [48:0] p2_reg;
    logic [63:0]        pc_reg;
    logic [32:0]        den_reg;
    logic               h_mism_reg;
    logic               h_rev_reg;
    logic signed [15:0] h_mv_reg;
    logic signed [15:0] h_sv_reg;
    logic [31:0]        h_mc_reg;
    always_ff @(posedge clk)
    begin
        p1_reg     <= 49'(g_mv_reg) * $signed({1'b0, g_cs_reg});
        p2_reg     <= 49'(g_sv_reg) * $signed({1'b0, g_cm_reg});
        pc_reg     <= g_cm_reg * g_cs_reg;
        den_reg    <= {1'b0, g_cm_reg} + {1'b0, g_cs_reg};
        h_mism_reg <= g_mism_reg;
        h_rev_reg  <= g_rev_reg;
        h_mv_reg   <= g_mv_reg;
        h_sv_reg   <= g_sv_reg;
        h_mc_reg   <= g_mc_reg;
    end

    // gate stage 3: rounded numerators
    logic signed [49:0] num;
    logic [49:0]        mag;
    assign num = 50'(p1_reg) + 50'(p2_reg);
    assign mag = num[49] ? (50'd0 - num) : num;

    logic [63:0]        nv_reg;
    logic [63:0]        nc_reg;
    logic [32:0]        k_den_reg;
    logic               k_neg_reg;
    logic               k_mism_reg;
    logic               k_rev_reg;
    logic signed [15:0] k_mv_reg;
    logic signed [15:0] k_sv_reg;
    logic [31:0]        k_mc_reg;
    always_ff @(posedge clk)
    begin
        nv_reg     <= 64'(mag) + 64'(den_reg[32:1]);
        nc_reg     <= pc_reg + 64'(den_reg[32:1]);
        k_den_reg  <= den_reg;
        k_neg_reg  <= num[49];
        k_mism_reg <= h_mism_reg;
        k_rev_reg  <= h_rev_reg;
        k_mv_reg   <= h_mv_reg;
        k_sv_reg   <= h_sv_reg;
        k_mc_reg   <= h_mc_reg;
    end

    logic [63:0] qv;
    logic [63:0] qc;
    gvf_divider u_dv (.clk(clk), .num(nv_reg), .den(k_den_reg), .quo(qv));
    gvf_divider u_dc (.clk(clk), .num(nc_reg), .den(k_den_reg), .quo(qc));

    logic               e_neg_reg  [LatDiv];
    logic               e_mism_reg [LatDiv];
    logic               e_rev_reg  [LatDiv];
    logic signed [15:0] e_mv_reg   [LatDiv];
    logic signed [15:0] e_sv_reg   [LatDiv];
    logic [31:0]        e_mc_reg   [LatDiv];
    logic [1:0]         e_pol_reg  [LatDiv];
    always_ff @(posedge clk)
    begin
        e_neg_reg[0]  <= k_neg_reg;
        e_mism_reg[0] <= k_mism_reg;
        e_rev_reg[0]  <= k_rev_reg;
        e_mv_reg[0]   <= k_mv_reg;
        e_sv_reg[0]   <= k_sv_reg;
        e_mc_reg[0]   <= k_mc_reg;
        e_pol_reg[0]  <= policy_reg;
        for (int i = 1; i < LatDiv; i++)
        begin
            e_neg_reg[i]  <= e_neg_reg[i-1];
            e_mism_reg[i] <= e_mism_reg[i-1];
            e_rev_reg[i]  <= e_rev_reg[i-1];
            e_mv_reg[i]   <= e_mv_reg[i-1];
            e_sv_reg[i]   <= e_sv_reg[i-1];
            e_mc_reg[i]   <= e_mc_reg[i-1];
            e_pol_reg[i]  <= e_pol_reg[i-1];
        end
    end

    // clamp the mean
    logic signed [15:0] fv_next;
    logic signed [15:0] fv_reg;
    logic [31:0]        fc_reg;
    logic               f_mism_reg;
    logic               f_rev_reg;
    logic signed [15:0] f_mv_reg;
    logic signed [15:0] f_sv_reg;
    logic [31:0]        f_mc_reg;
    policy_t            f_pol_reg;
    always_comb
    begin
        if (e_neg_reg[LatDiv-1])
            fv_next = (qv > 64'd32768) ? -16'sd32768 : 16'(64'd0 - qv);
        else
            fv_next = (qv > 64'd32767) ? 16'sd32767 : qv[15:0];
    end
    always_ff @(posedge clk)
    begin
        fv_reg     <= fv_next;
        fc_reg     <= qc[31:0];
        f_mism_reg <= e_mism_reg[LatDiv-1];
        f_rev_reg  <= e_rev_reg[LatDiv-1];
        f_mv_reg   <= e_mv_reg[LatDiv-1];
        f_sv_reg   <= e_sv_reg[LatDiv-1];
        f_mc_reg   <= e_mc_reg[LatDiv-1];
        f_pol_reg  <= policy_t'(e_pol_reg[LatDiv-1]);
    end

    // output register
    logic signed [15:0] vx_next;
    logic [31:0]        cov_next;
    status_t            st_next;
    always_comb
    begin
        vx_next  = f_mv_reg;
        cov_next = f_mc_reg;
        if (f_mism_reg)
            st_next = ST_MISMATCH;
        else
        begin
            case (f_pol_reg)
                POL_SKIP:      st_next = ST_SKIPPED;
                POL_OVERWRITE:
                begin
                    st_next = ST_OVERWRITE;
                    vx_next = f_sv_reg;
                end
                POL_FUSION:
                begin
                    st_next  = ST_FUSED;
                    vx_next  = fv_reg;
                    cov_next = fc_reg;
                end
                default:       st_next = ST_UNKNOWN;
            endcase
        end
    end

    logic signed [15:0] vx_reg;
    logic [31:0]        cov_reg;
    status_t            st_reg;
    logic               rv_reg;
    always_ff @(posedge clk)
    begin
        vx_reg  <= vx_next;
        cov_reg <= cov_next;
        st_reg  <= st_next;
        rv_reg  <= f_rev_reg;
    end

    assign out_vx       = vx_reg;
    assign out_cov      = cov_reg;
    assign status       = st_reg;
    assign sub_reverted = rv_reg;

    a_mism_no_rev: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_MISMATCH) |-> !sub_reverted)
        else $error("revert flagged on mismatch");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Latency-2] |=> done)
        else $error("done strobe lost");
    a_skip_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_SKIPPED) |-> out_cov == $past(f_mc_reg))
        else $error("skip changed covariance");
endmodule
`default_nettype wire

FILE: rtl/gvf_cordic_cell.sv
// one vectoring cordic micro-rotation stage
`default_nettype none
module gvf_cordic_cell
    import gvf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [4:0] step,
    input  wire cordic_t    in_c,
    output cordic_t         out_c
);
    cordic_t c_next;
    cordic_t c_reg;

    // step is tied to a constant per cell, so the shifts reduce to wiring
    always_comb
    begin
        c_next = in_c;
        if (in_c.y >= 0)
        begin
            c_next.x = in_c.x + (in_c.y >>> step);
            c_next.y = in_c.y - (in_c.x >>> step);
            c_next.z = in_c.z + atan_lut(int'(step));
        end
        else
        begin
            c_next.x = in_c.x - (in_c.y >>> step);
            c_next.y = in_c.y + (in_c.x >>> step);
            c_next.z = in_c.z - atan_lut(int'(step));
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign out_c = c_reg;
endmodule
`default_nettype wire

FILE: rtl/gvf_cordic.sv
// pipelined atan2 as a chain of cordic cells
`default_nettype none
module gvf_cordic
    import gvf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    output logic [15:0]             angle
);
    cordic_t pre_next;
    cordic_t pre_reg;
    cordic_t chain [CordicSteps+1];
    logic [31:0] zr;

    always_comb
    begin
        pre_next.x    = CordicW'(x) <<< 24;
        pre_next.y    = CordicW'(y) <<< 24;
        pre_next.z    = 32'h0;
        pre_next.zero = (x == 16'sd0) && (y == 16'sd0);
        if (x < 0)
        begin
            pre_next.x = -pre_next.x;
            pre_next.y = -pre_next.y;
            pre_next.z = 32'h80000000;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
    end

    assign chain[0] = pre_reg;

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_cell
        gvf_cordic_cell u_cell (
            .clk  (clk),
            .step (5'(i)),
            .in_c (chain[i]),
            .out_c(chain[i+1])
        );
    end

    assign zr    = chain[CordicSteps].z + 32'h8000;
    assign angle = chain[CordicSteps].zero ? 16'h0 : zr[31:16];
endmodule
`default_nettype wire

FILE: rtl/gvf_div_cell.sv
// one restoring divider cell, one quotient bit per stage
`default_nettype none
module gvf_div_cell
    import gvf_pkg::*;
(
    input  wire logic clk,
    input  wire div_t in_d,
    output div_t      out_d
);
    div_t d_next;
    div_t d_reg;
    logic [DivW:0] trial;

    always_comb
    begin
        d_next = in_d;
        trial  = {in_d.rem, in_d.quo[63]} - {1'b0, in_d.den};
        d_next.quo = {in_d.quo[62:0], ~trial[DivW]};
        d_next.rem = trial[DivW] ? {in_d.rem[DivW-2:0], in_d.quo[63]} : trial[DivW-1:0];
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign out_d = d_reg;
endmodule
`default_nettype wire

FILE: rtl/gvf_divider.sv
// pipelined unsigned 64 by 33 bit divider as a chain of cells
`default_nettype none
module gvf_divider
    import gvf_pkg::*;
(
    input  wire logic            clk,
    input  wire logic [63:0]     num,
    input  wire logic [DivW-1:0] den,
    output logic [63:0]          quo
);
    div_t chain [LatDiv+1];

    // quotient fits 50 bits here: remainder starts from top 14 bits
    assign chain[0].rem = {{(DivW-14){1'b0}}, num[63:50]};
    assign chain[0].quo = {num[49:0], 14'h0};
    assign chain[0].den = den;

    for (genvar i = 0; i < LatDiv; i++)
    begin : g_cell
        gvf_div_cell u_cell (
            .clk  (clk),
            .in_d (chain[i]),
            .out_d(chain[i+1])
        );
    end

    // quotient bits are shifted in from the bottom
    assign quo = {14'h0, chain[LatDiv].quo[49:0]};
endmodule
`default_nettype wire
